### sv/adbm_pkg.sv
`default_nettype none
package adbm_pkg;

  // preamble codes
  localparam logic [2:0] PRE_DATA = 3'd0;
  localparam logic [2:0] PRE_CMD  = 3'd6;
  localparam logic [2:0] PRE_REP  = 3'd7;

  // packed header characters D, B, M
  localparam logic [20:0] HDR_DBM = {7'h44, 7'h42, 7'h4D};

  // crc-16/ccitt
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_CRC_ENABLE = '0;

  // one radio word with its end flag
  typedef struct packed {
    logic [2:0]  pre;
    logic [20:0] payload;
    logic        last;
  } word_t;

  // words caused by one request
  typedef struct packed {
    logic [1:0]       cnt;
    word_t [2:0]      words;
  } rec_t;

endpackage
`default_nettype wire

### sv/adbm_front.sv
`default_nettype none
module adbm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            crc_en,
  input  wire logic            acc,
  input  wire logic [7:0]      data_byte,
  input  wire logic            byte_present,
  input  wire logic            end_of_message,
  output adbm_pkg::rec_t       rec,
  output logic                 rec_push
);

  logic        in_msg_r, in_msg_nxt;
  logic        nid_r, nid_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [6:0]  held0_r, held0_nxt;
  logic [6:0]  held1_r, held1_nxt;
  logic [15:0] crc_r, crc_nxt;

  // one byte through the crc, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ adbm_pkg::CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  // classify the request and build its words
  always_comb begin
    adbm_pkg::rec_t r;
    logic           nid;
    logic [1:0]     fill;
    logic [6:0]     h0;
    logic [6:0]     h1;
    logic [15:0]    crc;
    logic           active;
    r      = '0;
    nid    = in_msg_r ? nid_r : 1'b1;
    fill   = fill_r;
    h0     = held0_r;
    h1     = held1_r;
    crc    = crc_r;
    active = byte_present | end_of_message;

    // header word at message start
    if (!in_msg_r) begin
      r.words[0] = '{pre: adbm_pkg::PRE_CMD, payload: adbm_pkg::HDR_DBM, last: 1'b0};
      r.cnt      = 2'd1;
    end

    // byte: crc, then hold or complete a triplet
    if (byte_present) begin
      crc = crc_byte(crc_r, data_byte);
      if (fill_r == 2'd2) begin
        r.words[r.cnt] = '{pre: nid ? adbm_pkg::PRE_DATA : adbm_pkg::PRE_REP,
                           payload: {h0, h1, data_byte[6:0]}, last: 1'b0};
        r.cnt = r.cnt + 2'd1;
        nid   = ~nid;
        fill  = 2'd0;
        h0    = '0;
        h1    = '0;
      end else begin
        if (fill_r[0]) h1 = data_byte[6:0];
        else           h0 = data_byte[6:0];
        fill = fill_r + 2'd1;
      end
    end

    // message end: padded partial triplet, then crc word if enabled
    if (end_of_message) begin
      if (fill != 2'd0) begin
        r.words[r.cnt] = '{pre: nid ? adbm_pkg::PRE_DATA : adbm_pkg::PRE_REP,
                           payload: {h0, (fill == 2'd2) ? h1 : 7'd0, 7'd0}, last: 1'b0};
        r.cnt = r.cnt + 2'd1;
        nid   = ~nid;
      end
      if (crc_en) begin
        r.words[r.cnt] = '{pre: nid ? adbm_pkg::PRE_DATA : adbm_pkg::PRE_REP,
                           payload: {crc[14:8], crc[6:0], 7'd0}, last: 1'b0};
        r.cnt = r.cnt + 2'd1;
        nid   = ~nid;
      end
      for (int i = 0; i < 3; i++) begin
        if (r.cnt != 2'd0 && 2'(i) == r.cnt - 2'd1) r.words[i].last = 1'b1;
      end
    end

    rec      = r;
    rec_push = acc & active & (r.cnt != 2'd0);

    // message state update
    in_msg_nxt = in_msg_r;
    nid_nxt    = nid_r;
    fill_nxt   = fill_r;
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    crc_nxt    = crc_r;
    if (acc && active) begin
      if (end_of_message) begin
        in_msg_nxt = 1'b0;
        nid_nxt    = 1'b1;
        fill_nxt   = '0;
        held0_nxt  = '0;
        held1_nxt  = '0;
        crc_nxt    = adbm_pkg::CRC_INIT;
      end else begin
        in_msg_nxt = 1'b1;
        nid_nxt    = nid;
        fill_nxt   = fill;
        held0_nxt  = h0;
        held1_nxt  = h1;
        crc_nxt    = crc;
      end
    end
  end

  // message state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      nid_r    <= 1'b1;
      fill_r   <= '0;
      held0_r  <= '0;
      held1_r  <= '0;
      crc_r    <= adbm_pkg::CRC_INIT;
    end else begin
      in_msg_r <= in_msg_nxt;
      nid_r    <= nid_nxt;
      fill_r   <= fill_nxt;
      held0_r  <= held0_nxt;
      held1_r  <= held1_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/adbm_queue.sv
`default_nettype none
module adbm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire adbm_pkg::rec_t  wdata,
  input  wire logic            pop,
  output adbm_pkg::rec_t       rdata,
  output logic                 full,
  output logic                 not_empty
);

  adbm_pkg::rec_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rp_r];

  // record storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### sv/adbm_back.sv
`default_nettype none
module adbm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire adbm_pkg::rec_t  q_rdata,
  input  wire logic            q_valid,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [2:0]           out_preamble_code,
  output logic [20:0]          out_word_payload,
  output logic                 out_last_word
);

  adbm_pkg::rec_t rec_r;
  logic           rec_vld_r;
  logic [1:0]     idx_r;
  logic           ov_r;
  adbm_pkg::word_t ow_r;
  logic           out_free, take_word, rec_done;

  // word handoff into the output register
  assign out_free  = ~ov_r | ~out_stall;
  assign take_word = rec_vld_r & out_free;
  assign rec_done  = take_word & (idx_r == rec_r.cnt - 2'd1);
  assign q_pop     = q_valid & (~rec_vld_r | rec_done);

  // current record and word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (q_pop) begin
      rec_vld_r <= 1'b1;
      idx_r     <= '0;
    end else begin
      if (rec_done)  rec_vld_r <= 1'b0;
      if (take_word) idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) rec_r <= q_rdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take_word) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_word) ow_r <= rec_r.words[idx_r];
  end

  assign out_valid         = ov_r;
  assign out_preamble_code = ow_r.pre;
  assign out_word_payload  = ow_r.payload;
  assign out_last_word     = ow_r.last;

endmodule
`default_nettype wire

### sv/ale_data_block_message_encoder.sv
`default_nettype none
// Data block message encoder: takes message bytes and emits 24-bit radio words
// (3-bit preamble, 21-bit payload of three 7-bit characters). A message opens
// with a CMD header word "DBM", packs each byte triplet into alternating DATA
// and REP words, pads a partial triplet at the end and, when crc_enable is
// set, appends a CRC-16/CCITT word. An input request is taken every cycle
// while the two-entry record queue between the front and back has room; each
// request yields zero to three words and the back end sends one word per
// cycle while out_stall is low. Each word passes through the record queue,
// the back end's record register and its output register. crc_enable is
// written at byte address 0.
module ale_data_block_message_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_byte_present,
  input  wire logic                        in_end_of_message,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       out_preamble_code,
  output logic [20:0]                      out_word_payload,
  output logic                             out_last_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [adbm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic           crc_en_r;
  logic           reg_hit;
  logic           q_full, q_valid, q_pop, rec_push, in_acc;
  adbm_pkg::rec_t rec, q_rdata;

  // configuration register, decoded by word index
  assign pready  = 1'b1;
  assign reg_hit = (paddr[adbm_pkg::CFG_AW-1:2]
                    == adbm_pkg::REG_CRC_ENABLE[adbm_pkg::CFG_AW-1:2]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      crc_en_r <= pwdata[0];
    end
  end
  assign prdata = reg_hit ? {31'd0, crc_en_r} : 32'd0;

  // input handshake
  assign in_stall = q_full;
  assign in_acc   = in_valid & ~q_full;

  adbm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .crc_en         (crc_en_r),
    .acc            (in_acc),
    .data_byte      (in_data_byte),
    .byte_present   (in_byte_present),
    .end_of_message (in_end_of_message),
    .rec            (rec),
    .rec_push       (rec_push)
  );

  adbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .wdata     (rec),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_valid)
  );

  adbm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_preamble_code (out_preamble_code),
    .out_word_payload  (out_word_payload),
    .out_last_word     (out_last_word)
  );

endmodule
`default_nettype wire

### sv/adbm_checker.sv
`default_nettype none
module adbm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_preamble_code,
  input wire logic [20:0] out_word_payload
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_preamble_code)
      && $stable(out_word_payload))
    else $error("stalled output word changed");

  // only defined preamble codes leave the block
  a_pre_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_preamble_code == adbm_pkg::PRE_DATA
      || out_preamble_code == adbm_pkg::PRE_CMD
      || out_preamble_code == adbm_pkg::PRE_REP))
    else $error("undefined preamble code");

  // a command word always carries the header characters
  a_cmd_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_preamble_code == adbm_pkg::PRE_CMD |->
      out_word_payload == adbm_pkg::HDR_DBM)
    else $error("command word without header payload");

  // reset empties the output and the queue
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind ale_data_block_message_encoder adbm_checker u_adbm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_preamble_code (out_preamble_code),
  .out_word_payload  (out_word_payload)
);
`default_nettype wire
